@@ src/sws_pkg.sv @@
package sws_pkg;

  localparam int unsigned STACK_DEPTH_DEF = 64;
  localparam int unsigned DATA_W          = 32;
  localparam int unsigned CAP_W           = 32;
  localparam int unsigned CFG_W           = 16;
  localparam int unsigned MODE_W          = 2;
  localparam int unsigned STATUS_W        = 2;

  localparam logic [CAP_W-1:0] RESET_CAPACITY = CAP_W'(3);

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH   = 2'd0,
    MODE_POP    = 2'd1,
    MODE_PEEK   = 2'd2,
    MODE_DELETE = 2'd3
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    DSEL_ZERO,
    DSEL_NEG1,
    DSEL_RAM
  } data_sel_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP,
    S_PEEK,
    S_SEARCH,
    S_SHIFT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic      latch;       // capture value, point at top, read top
    logic      push;        // write value at top, grow, maybe double capacity
    logic      ptr_dec;     // step search pointer down, read below
    logic      shift_start; // read entry above pointer
    logic      shift_step;  // write read data at pointer, advance pointer
    logic      dec_count;   // shrink by one
    logic      respond;     // load result registers and strobe
    status_t   st;
    data_sel_t dsel;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic empty;
    logic full;
    logic match;
    logic ptr_zero;
    logic ptr_top;
    logic shift_last;
  } stat_t;

  function automatic logic [CAP_W-1:0] double_sat(input logic [CAP_W-1:0] c);
    logic [CAP_W-1:0] r;
    if (c[CAP_W-1]) begin
      r = '1;
    end else begin
      r = {c[CAP_W-2:0], 1'b0};
    end
    return r;
  endfunction

endpackage

@@ src/stack_with_delete_by_value_top.sv @@
// Channel   Ports                                           Transaction when
// --------  ----------------------------------------------  ------------------------
// request   start, busy, mode, value                        start && !busy at clk
// result    done, data, status, size_now, is_empty,         done high (one cycle)
//           capacity_now
// config    cfg_we, cfg_wdata (initial_capacity)            cfg_we at clk
//
// Push, and any request that fails at once (full push, empty pop/peek/delete), is done in
// the idle state; pop and peek wait on the registered read of the entry RAM.
// Delete searches the entries from the top, then moves the entries above the match down
// one place; the single RAM read port sets that pace.
// The result appears on the cycle after the last edge of its request, for one cycle.
// rst (synchronous, active high) empties the stack and sets the capacity count to 3;
// the receiver cannot stall, so done is never held.
module stack_with_delete_by_value_top #(
  parameter int unsigned STACK_DEPTH = sws_pkg::STACK_DEPTH_DEF,
  localparam int unsigned CNT_W = $clog2(STACK_DEPTH + 1)
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [sws_pkg::MODE_W-1:0]        mode,
  input  logic signed [sws_pkg::DATA_W-1:0] value,
  input  logic                              cfg_we,
  input  logic [sws_pkg::CFG_W-1:0]         cfg_wdata,
  output logic                              done,
  output logic signed [sws_pkg::DATA_W-1:0] data,
  output logic [sws_pkg::STATUS_W-1:0]      status,
  output logic [CNT_W-1:0]                  size_now,
  output logic                              is_empty,
  output logic [sws_pkg::CAP_W-1:0]         capacity_now
);
  import sws_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // Sequence each transaction: decode the mode, walk the search, drive the shifts
  sws_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .mode  (mode),
    .stat  (stat),
    .busy  (busy),
    .cmd   (cmd)
  );

  // Hold the entries, the fill count and the capacity count; register the result
  sws_datapath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .value        (value),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .done         (done),
    .data         (data),
    .status       (status),
    .size_now     (size_now),
    .is_empty     (is_empty),
    .capacity_now (capacity_now)
  );

endmodule

@@ src/sws_ram.sv @@
module sws_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ src/sws_datapath.sv @@
module sws_datapath #(
  parameter int unsigned STACK_DEPTH = sws_pkg::STACK_DEPTH_DEF,
  localparam int unsigned ADDR_W = $clog2(STACK_DEPTH),
  localparam int unsigned CNT_W  = $clog2(STACK_DEPTH + 1)
) (
  input  logic                           clk,
  input  logic                           rst,
  input  sws_pkg::cmd_t                  cmd,
  output sws_pkg::stat_t                 stat,
  input  logic signed [sws_pkg::DATA_W-1:0] value,
  input  logic                           cfg_we,
  input  logic [sws_pkg::CFG_W-1:0]      cfg_wdata,
  output logic                           done,
  output logic signed [sws_pkg::DATA_W-1:0] data,
  output logic [sws_pkg::STATUS_W-1:0]   status,
  output logic [CNT_W-1:0]               size_now,
  output logic                           is_empty,
  output logic [sws_pkg::CAP_W-1:0]      capacity_now
);
  import sws_pkg::*;

  logic [CNT_W-1:0]  count, count_next;
  logic [CAP_W-1:0]  cap, cap_next;
  logic [ADDR_W-1:0] ptr, ptr_next;
  logic [DATA_W-1:0] value_reg;
  logic [ADDR_W-1:0] top_addr;
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  logic [DATA_W-1:0] rd_data, wr_data;
  logic              we;
  logic [DATA_W-1:0] data_sel;

  assign top_addr = ADDR_W'(count - CNT_W'(1));

  sws_ram #(
    .WIDTH (DATA_W),
    .DEPTH (STACK_DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (we),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Write port: push at the top, or move an entry down one place
  always_comb begin
    we      = cmd.push | cmd.shift_step;
    wr_addr = ptr;
    wr_data = rd_data;
    if (cmd.push) begin
      wr_addr = ADDR_W'(count);
      wr_data = value;
    end
  end

  // Read port and search pointer
  always_comb begin
    rd_addr  = ptr;
    ptr_next = ptr;
    if (cmd.latch) begin
      rd_addr  = top_addr;
      ptr_next = top_addr;
    end else if (cmd.ptr_dec) begin
      rd_addr  = ptr - ADDR_W'(1);
      ptr_next = ptr - ADDR_W'(1);
    end else if (cmd.shift_start) begin
      rd_addr  = ptr + ADDR_W'(1);
    end else if (cmd.shift_step) begin
      rd_addr  = ptr + ADDR_W'(1) + ADDR_W'(1);
      ptr_next = ptr + ADDR_W'(1);
    end
  end

  always_comb begin
    count_next = count;
    cap_next   = cap;
    if (cmd.push) begin
      count_next = count + CNT_W'(1);
      if (CAP_W'(count) >= cap) begin
        cap_next = double_sat(cap);
      end
    end
    if (cmd.dec_count) begin
      count_next = count - CNT_W'(1);
    end
    if (cfg_we) begin
      cap_next = CAP_W'(cfg_wdata);
    end
  end

  always_comb begin
    case (cmd.dsel)
      DSEL_RAM:  data_sel = rd_data;
      DSEL_NEG1: data_sel = '1;
      default:   data_sel = '0;
    endcase
  end

  always_comb begin
    stat.empty      = (count == '0);
    stat.full       = (count == CNT_W'(STACK_DEPTH));
    stat.match      = (rd_data == value_reg);
    stat.ptr_zero   = (ptr == '0);
    stat.ptr_top    = (CNT_W'(ptr) == count - CNT_W'(1));
    stat.shift_last = (CNT_W'(ptr) + CNT_W'(1) == count - CNT_W'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      cap   <= RESET_CAPACITY;
      done  <= 1'b0;
    end else begin
      count <= count_next;
      cap   <= cap_next;
      done  <= cmd.respond;
    end
  end

  always_ff @(posedge clk) begin
    ptr <= ptr_next;
    if (cmd.latch) begin
      value_reg <= value;
    end
    if (cmd.respond) begin
      data         <= data_sel;
      status       <= cmd.st;
      size_now     <= count_next;
      is_empty     <= (count_next == '0);
      capacity_now <= cap_next;
    end
  end

endmodule

@@ src/sws_ctrl.sv @@
module sws_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [sws_pkg::MODE_W-1:0]   mode,
  input  sws_pkg::stat_t               stat,
  output logic                         busy,
  output sws_pkg::cmd_t                cmd
);
  import sws_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.st     = ST_OK;
    cmd.dsel   = DSEL_ZERO;
    busy       = (state != S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          unique case (mode_t'(mode))
            MODE_PUSH: begin
              cmd.respond = 1'b1;
              if (stat.full) begin
                cmd.st = ST_FULL;
              end else begin
                cmd.push = 1'b1;
              end
            end
            MODE_POP, MODE_PEEK: begin
              if (stat.empty) begin
                cmd.respond = 1'b1;
                cmd.st      = ST_UNDERFLOW;
                cmd.dsel    = DSEL_NEG1;
              end else begin
                state_next = (mode_t'(mode) == MODE_POP) ? S_POP : S_PEEK;
              end
            end
            MODE_DELETE: begin
              if (stat.empty) begin
                cmd.respond = 1'b1;
                cmd.st      = ST_NOT_FOUND;
              end else begin
                state_next = S_SEARCH;
              end
            end
            default: ;
          endcase
        end
      end
      S_POP: begin
        cmd.dec_count = 1'b1;
        cmd.respond   = 1'b1;
        cmd.dsel      = DSEL_RAM;
        state_next    = S_IDLE;
      end
      S_PEEK: begin
        cmd.respond = 1'b1;
        cmd.dsel    = DSEL_RAM;
        state_next  = S_IDLE;
      end
      S_SEARCH: begin
        if (stat.match) begin
          if (stat.ptr_top) begin
            cmd.dec_count = 1'b1;
            cmd.respond   = 1'b1;
            state_next    = S_IDLE;
          end else begin
            cmd.shift_start = 1'b1;
            state_next      = S_SHIFT;
          end
        end else if (stat.ptr_zero) begin
          cmd.respond = 1'b1;
          cmd.st      = ST_NOT_FOUND;
          state_next  = S_IDLE;
        end else begin
          cmd.ptr_dec = 1'b1;
        end
      end
      S_SHIFT: begin
        cmd.shift_step = 1'b1;
        if (stat.shift_last) begin
          cmd.dec_count = 1'b1;
          cmd.respond   = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

@@ tb/stack_with_delete_by_value_top_test.sv @@
module stack_with_delete_by_value_top_test;
  import sws_pkg::*;

  localparam int DEPTH      = STACK_DEPTH_DEF;
  localparam int CNT_W      = $clog2(DEPTH + 1);
  // Longest quiet stretch of a correct run: a full-depth delete behind the longest sender
  // gap, taken several times over.
  localparam int QUIET_LIMIT = 1500;
  localparam int TAIL_CYCLES = 2 * DEPTH + 8;
  localparam int PHASE_ITEMS = 95;
  localparam int N_PHASES    = 8;

  // One result transaction as the block should present it.
  typedef struct packed {
    logic signed [DATA_W-1:0] data;
    status_t                  status;
    logic [CNT_W-1:0]         size;
    logic                     empty;
    logic [CAP_W-1:0]         capacity;
  } stack_answer_t;

  // A row of the directed table; typed rows carry their expectation by hand.
  typedef struct packed {
    mode_t         op;
    logic [31:0]   operand;
    logic          typed;
    stack_answer_t answer;
  } stack_row_t;

  logic                     clk;
  logic                     rst;
  logic                     start;
  logic                     busy;
  logic [MODE_W-1:0]        mode;
  logic signed [DATA_W-1:0] value;
  logic                     cfg_we;
  logic [CFG_W-1:0]         cfg_wdata;
  logic                     done;
  logic signed [DATA_W-1:0] data;
  logic [STATUS_W-1:0]      status;
  logic [CNT_W-1:0]         size_now;
  logic                     is_empty;
  logic [CAP_W-1:0]         capacity_now;

  // Predictor state: our own copy of the stack, its fill and the capacity count.
  logic [DATA_W-1:0] shadow_stack [DEPTH];
  int                shadow_fill;
  logic [CAP_W-1:0]  shadow_capacity;

  stack_answer_t answer_q [$];
  stack_row_t    directed_rows [$];
  stack_answer_t seen;

  int fail_count;
  int accepted_count;
  int checked_count;
  int full_drops;
  int underflows;
  int missed_deletes;
  int deletes_hit;
  int settings_used;
  int idle_pct;
  int quiet_cycles;

  stack_with_delete_by_value_top uut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .mode         (mode),
    .value        (value),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .done         (done),
    .data         (data),
    .status       (status),
    .size_now     (size_now),
    .is_empty     (is_empty),
    .capacity_now (capacity_now)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Work out the result of one request and advance the shadow stack.
  function automatic stack_answer_t stack_predict(input mode_t op, input logic [31:0] operand);
    stack_answer_t a;
    int hit;
    a.data   = '0;
    a.status = ST_OK;
    case (op)
      MODE_PUSH: begin
        if (shadow_fill >= DEPTH) begin
          // drop the word, leave the capacity count alone
          a.status = ST_FULL;
          full_drops++;
        end else begin
          if (CAP_W'(shadow_fill) >= shadow_capacity)
            shadow_capacity = shadow_capacity[CAP_W-1] ? '1 : shadow_capacity << 1;
          shadow_stack[shadow_fill] = operand;
          shadow_fill++;
        end
      end
      MODE_POP, MODE_PEEK: begin
        if (shadow_fill == 0) begin
          a.data   = -1;
          a.status = ST_UNDERFLOW;
          underflows++;
        end else begin
          a.data = shadow_stack[shadow_fill - 1];
          if (op == MODE_POP) shadow_fill--;
        end
      end
      default: begin
        // search from the top, then close the gap above the match
        hit = -1;
        for (int i = shadow_fill - 1; i >= 0; i--) begin
          if (hit < 0 && shadow_stack[i] == operand) hit = i;
        end
        if (hit < 0) begin
          a.status = ST_NOT_FOUND;
          missed_deletes++;
        end else begin
          for (int k = hit; k + 1 < shadow_fill; k++) shadow_stack[k] = shadow_stack[k + 1];
          shadow_fill--;
          deletes_hit++;
        end
      end
    endcase
    a.size     = CNT_W'(shadow_fill);
    a.empty    = (shadow_fill == 0);
    a.capacity = shadow_capacity;
    return a;
  endfunction

  // Offer one request, idling beforehand at the current rate, and hold it until the
  // block takes the transaction. Called only on a rising edge.
  task automatic issue_request(input mode_t op, input logic [31:0] operand,
                               input logic typed, input stack_answer_t fixed);
    int gap;
    stack_answer_t a;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      // drop start and scramble the payload while idle
      start <= 1'b0;
      mode  <= MODE_W'($urandom);
      value <= $urandom;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    mode  <= op;
    value <= operand;
    @(posedge clk);
    while (busy) @(posedge clk);
    a = stack_predict(op, operand);
    answer_q.push_back(typed ? fixed : a);
    accepted_count++;
  endtask

  // Write initial_capacity once the block has gone quiet; the count reloads with it.
  task automatic load_capacity(input logic [CFG_W-1:0] cap);
    start <= 1'b0;
    @(posedge clk);
    while (answer_q.size() != 0 || busy) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= cap;
    @(posedge clk);
    cfg_we          <= 1'b0;
    shadow_capacity = CAP_W'(cap);
    settings_used++;
  endtask

  task automatic add_row(input mode_t op, input logic [31:0] operand, input logic typed,
                         input logic [31:0] d, input status_t st, input int sz,
                         input logic [CAP_W-1:0] cap);
    stack_row_t r;
    r.op              = op;
    r.operand         = operand;
    r.typed           = typed;
    r.answer.data     = d;
    r.answer.status   = st;
    r.answer.size     = CNT_W'(sz);
    r.answer.empty    = (sz == 0);
    r.answer.capacity = cap;
    directed_rows.push_back(r);
  endtask

  // Half the words from a tiny pool, so deletes find duplicates; some extremes, some noise.
  function automatic logic [31:0] pick_word();
    logic [31:0] w;
    case ($urandom_range(9))
      0, 1, 2, 3, 4: w = 32'($urandom_range(7));
      5: begin
        case ($urandom_range(3))
          0: w = 32'h0000_0000;
          1: w = 32'hFFFF_FFFF;
          2: w = 32'h7FFF_FFFF;
          default: w = 32'h8000_0000;
        endcase
      end
      default: w = $urandom;
    endcase
    return w;
  endfunction

  // Check each result transaction against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (answer_q.size() == 0) begin
        $error("result transaction with nothing expected");
        fail_count++;
      end else begin
        seen = answer_q.pop_front();
        checked_count++;
        if (data !== seen.data) begin
          $error("data: expected %0d, got %0d", seen.data, data);
          fail_count++;
        end
        if (status !== seen.status) begin
          $error("status: expected %0d, got %0d", seen.status, status);
          fail_count++;
        end
        if (size_now !== seen.size) begin
          $error("size_now: expected %0d, got %0d", seen.size, size_now);
          fail_count++;
        end
        if (is_empty !== seen.empty) begin
          $error("is_empty: expected %0d, got %0d", seen.empty, is_empty);
          fail_count++;
        end
        if (capacity_now !== seen.capacity) begin
          $error("capacity_now: expected %0h, got %0h", seen.capacity, capacity_now);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: end the run if neither channel moves a transaction for too long.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("stack_with_delete_by_value_top test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    stack_answer_t none;
    mode_t         op;
    logic [31:0]   word;
    int            push_pct;
    logic [CFG_W-1:0] phase_caps [N_PHASES];

    // Hold every input at a known value from time zero.
    rst             = 1'b1;
    start           = 1'b0;
    mode            = MODE_PUSH;
    value           = '0;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    none            = '0;
    fail_count      = 0;
    accepted_count  = 0;
    checked_count   = 0;
    full_drops      = 0;
    underflows      = 0;
    missed_deletes  = 0;
    deletes_hit     = 0;
    settings_used   = 1;
    idle_pct        = 0;
    quiet_cycles    = 0;
    shadow_fill     = 0;
    shadow_capacity = RESET_CAPACITY;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table. Typed rows: underflow and miss on the empty stack after reset and
    // after draining, extreme words going in, the first doubling of the count from its
    // reset value of three. The rest (duplicates, delete from the top and from the bottom,
    // draining) go to the predictor.
    add_row(MODE_POP,    32'h0,         1'b1, 32'hFFFF_FFFF, ST_UNDERFLOW, 0, 3);
    add_row(MODE_PEEK,   32'h0,         1'b1, 32'hFFFF_FFFF, ST_UNDERFLOW, 0, 3);
    add_row(MODE_DELETE, 32'h0,         1'b1, 32'h0,         ST_NOT_FOUND, 0, 3);
    add_row(MODE_PUSH,   32'h7FFF_FFFF, 1'b1, 32'h0,         ST_OK,        1, 3);
    add_row(MODE_PUSH,   32'h8000_0000, 1'b1, 32'h0,         ST_OK,        2, 3);
    add_row(MODE_PUSH,   32'hFFFF_FFFF, 1'b1, 32'h0,         ST_OK,        3, 3);
    add_row(MODE_PUSH,   32'h0,         1'b1, 32'h0,         ST_OK,        4, 6);
    add_row(MODE_PEEK,   32'h5A5A_A5A5, 1'b1, 32'h0,         ST_OK,        4, 6);
    add_row(MODE_PUSH,   32'h5,         1'b0, 32'h0,         ST_OK,        0, 0);
    add_row(MODE_PUSH,   32'h8000_0000, 1'b0, 32'h0,         ST_OK,        0, 0);
    add_row(MODE_PUSH,   32'h5,         1'b0, 32'h0,         ST_OK,        0, 0);
    add_row(MODE_DELETE, 32'h8000_0000, 1'b0, 32'h0,         ST_OK,        0, 0);
    add_row(MODE_DELETE, 32'h7FFF_FFFF, 1'b0, 32'h0,         ST_OK,        0, 0);
    add_row(MODE_DELETE, 32'h0000_3039, 1'b0, 32'h0,         ST_OK,        0, 0);
    add_row(MODE_DELETE, 32'h5,         1'b0, 32'h0,         ST_OK,        0, 0);
    add_row(MODE_POP,    32'hFFFF_FFFF, 1'b0, 32'h0,         ST_OK,        0, 0);
    add_row(MODE_PEEK,   32'h0,         1'b0, 32'h0,         ST_OK,        0, 0);
    add_row(MODE_POP,    32'h0,         1'b0, 32'h0,         ST_OK,        0, 0);
    add_row(MODE_POP,    32'h0,         1'b0, 32'h0,         ST_OK,        0, 0);
    add_row(MODE_POP,    32'h0,         1'b0, 32'h0,         ST_OK,        0, 0);
    add_row(MODE_POP,    32'h0,         1'b1, 32'hFFFF_FFFF, ST_UNDERFLOW, 0, 12);
    add_row(MODE_DELETE, 32'hFFFF_FFFF, 1'b1, 32'h0,         ST_NOT_FOUND, 0, 12);

    foreach (directed_rows[i])
      issue_request(directed_rows[i].op, directed_rows[i].operand,
                    directed_rows[i].typed, directed_rows[i].answer);

    // Fill to the brim and push twice more: both extra pushes must be dropped with the
    // count unchanged. Then delete the bottom word, the longest search and shift.
    for (int i = 0; i < DEPTH + 2; i++)
      issue_request(MODE_PUSH, (i == 0) ? 32'hC0DE_0001 : $urandom, 1'b0, none);
    issue_request(MODE_DELETE, 32'hC0DE_0001, 1'b0, none);

    // Capacity settings per phase: zero (stays zero when doubled), one, the largest,
    // the reset value, and a few others. Saturation of the count cannot be reached with
    // 64 entries, so the predictor's saturating branch stays idle here.
    phase_caps[0] = 16'h0000;
    phase_caps[1] = 16'h0001;
    phase_caps[2] = 16'hFFFF;
    phase_caps[3] = 16'h0003;
    phase_caps[4] = CFG_W'($urandom_range(64));
    phase_caps[5] = 16'h0002;
    phase_caps[6] = 16'h0028;
    phase_caps[7] = CFG_W'($urandom);

    for (int ph = 0; ph < N_PHASES; ph++) begin
      load_capacity(phase_caps[ph]);
      // Sender idling rates: none, heavy, none, light.
      case (ph % 4)
        0: idle_pct = 0;
        1: idle_pct = 70;
        2: idle_pct = 0;
        default: idle_pct = 25;
      endcase
      push_pct = 50;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Swing between filling and draining so the stack runs full and empty often.
        if (n % 32 == 0) begin
          case ($urandom_range(2))
            0: push_pct = 20;
            1: push_pct = 50;
            default: push_pct = 85;
          endcase
        end
        if ($urandom_range(99) < push_pct) begin
          op = MODE_PUSH;
        end else begin
          case ($urandom_range(2))
            0: op = MODE_POP;
            1: op = MODE_PEEK;
            default: op = MODE_DELETE;
          endcase
        end
        word = pick_word();
        // Most deletes target a word that is really stored somewhere in the stack.
        if (op == MODE_DELETE && shadow_fill > 0 && $urandom_range(99) < 70)
          word = shadow_stack[$urandom_range(shadow_fill - 1)];
        issue_request(op, word, 1'b0, none);
      end
    end

    // Drain: wait for every expected result, then allow a full-depth delete's worth of
    // cycles so any stray result transaction shows up.
    start <= 1'b0;
    @(posedge clk);
    while (answer_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d requests over %0d capacity settings, %0d results checked.",
             accepted_count, settings_used, checked_count);
    $display("Full pushes dropped %0d, underflows %0d, deletes hit %0d, missed %0d.",
             full_drops, underflows, deletes_hit, missed_deletes);
    if (fail_count == 0) begin
      $display("stack_with_delete_by_value_top test passed");
    end else begin
      $display("stack_with_delete_by_value_top test failed");
    end
    $finish;
  end

endmodule
